FILE: rtl/lgmt_pkg.sv
// Shared types, constants and helper functions for the layered least-toll query block.
// Depends on nothing; used by layered_graph_min_toll_query and its testbench.
package lgmt_pkg;

  // Graph geometry.
  localparam int NODES       = 4096;
  localparam int LEVELS      = 12;
  localparam int LAYER_WIDTH = 5;

  localparam int NODE_W    = 12;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int OFF_W     = 3;
  localparam int TOLL_W    = 14;
  localparam int COST_W    = 28;
  localparam int OUTC_W    = 27;
  localparam int MID_W     = NODE_W + 4;
  localparam int NCNT_W    = 13;
  localparam int ROW_DEPTH = NODES * LEVELS;
  localparam int ADDR_W    = $clog2(ROW_DEPTH);
  localparam int ROW_W     = LAYER_WIDTH * COST_W;

  localparam logic [COST_W-1:0] UNREACH = COST_W'(1) << (COST_W - 1);

  typedef logic [COST_W-1:0]                   cost_t;
  typedef logic [LAYER_WIDTH-1:0][COST_W-1:0]  row_t;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_LAYER_SIZE = 1'b0,
    CFG_NODE_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_EREM, S_EWR, S_QREM, S_QBIT,
    S_BRA, S_BBASE, S_MRD, S_ACC, S_BWR, S_QUPD, S_OUT
  } state_e;

  // Saturating add: anything at or above the unreachable code stays there.
  function automatic cost_t sat_add(cost_t a, cost_t b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a >= UNREACH || b >= UNREACH || s >= {1'b0, UNREACH}) begin
      return UNREACH;
    end
    return s[COST_W-1:0];
  endfunction

  // Layer size as used: zero acts as one, large values clamp to the layer width.
  function automatic logic [OFF_W-1:0] eff_ls(logic [2:0] ls);
    if (ls == 3'd0) begin
      return OFF_W'(1);
    end
    if (32'(ls) > LAYER_WIDTH) begin
      return OFF_W'(LAYER_WIDTH);
    end
    return OFF_W'(ls);
  endfunction

  // Node divided by the layer size, by reciprocal multiplication exact for 12-bit nodes.
  function automatic logic [NODE_W-1:0] div_ls(logic [NODE_W-1:0] n, logic [OFF_W-1:0] ls);
    logic [NODE_W+13:0] p;
    logic [NODE_W-1:0]  q;
    p = '0;
    case (ls)
      3'd2: q = n >> 1;
      3'd3: begin
        p = (NODE_W+14)'(n) * (NODE_W+14)'(2731);
        q = p[NODE_W+12:13];
      end
      3'd4: q = n >> 2;
      3'd5: begin
        p = (NODE_W+14)'(n) * (NODE_W+14)'(3277);
        q = p[NODE_W+13:14];
      end
      default: q = n;
    endcase
    return q;
  endfunction

  // Row address of a node at a jump level.
  function automatic logic [ADDR_W-1:0] row_addr(logic [NODE_W-1:0] node, logic [LVL_W-1:0] lvl);
    return ADDR_W'(ADDR_W'(node) * ADDR_W'(LEVELS) + ADDR_W'(lvl));
  endfunction

endpackage

FILE: rtl/lgmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/layered_graph_min_toll_query.sv
// Top level of the layered least-toll query block: sequencer, shared min-plus unit, table RAM.
// Depends on lgmt_pkg and lgmt_ram.
//
// After reset the block clears the jump table (one row of five tolls per cycle) and stalls
// input meanwhile; configuration writes are taken at any time. One item is handled at a time
// and the table RAM port sets the pace. An add-edge item reads the source row and writes it
// back, or ends after the read when it is ignored. A query reads L rows per set bit of the
// layer distance, L being the layer size; a build rewrites every node's row at levels 1 to 11,
// reading L + 1 rows per node and level. Build and query results go through an output
// register, so a new item is taken while a result still waits.
module layered_graph_min_toll_query
  import lgmt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [NCNT_W-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [NODE_W-1:0]   from_node_i,
  input  logic [NODE_W-1:0]   to_node_i,
  input  logic [TOLL_W-1:0]   toll_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                answer_kind_o,
  output logic                reachable_o,
  output logic [OUTC_W-1:0]   cost_o
);

  state_e state_q, state_d;

  logic [2:0]         layer_size_q;
  logic [NCNT_W-1:0]  node_count_q;
  logic [OFF_W-1:0]   ls;

  logic [ADDR_W-1:0]  clr_q;
  logic [1:0]         kind_q;
  logic [NODE_W-1:0]  from_q, to_q, la_q, lb_q, d_q, layer_q, i_q, li_q;
  logic [TOLL_W-1:0]  toll_q;
  logic [OFF_W-1:0]   off_q, ob_q, o1_q, oi_q;
  logic [LVL_W-1:0]   j_q;
  logic               build_q, mid_ok_q, edge_ok;
  logic [MID_W-1:0]   base_q, mid;
  row_t               a_q, best_q, acc_row, rdata, wdata, init_row;
  logic [ROW_W-1:0]   rdata_raw;
  logic               pend_kind_q;
  cost_t              pend_cost_q;
  logic               out_free, q_bad;
  logic [LVL_W-1:0]   rlvl;
  logic [OFF_W-1:0]   oa;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;

  assign ls    = eff_ls(layer_size_q);
  assign rdata = row_t'(rdata_raw);
  assign mid   = base_q + MID_W'(o1_q);
  assign rlvl  = build_q ? LVL_W'(j_q - LVL_W'(1)) : j_q;
  assign out_free = !out_valid_o || !out_stall_i;

  assign edge_ok = ({1'b0, lb_q} == {1'b0, la_q} + (NODE_W+1)'(1));
  assign oa      = OFF_W'(from_q - NODE_W'(la_q * NODE_W'(ls)));
  assign q_bad   = (lb_q < la_q) || ((32'(lb_q - la_q) >> LEVELS) != 0);

  // Starting frontier of a query: zero at the start offset, unreachable elsewhere.
  always_comb begin
    init_row     = '{default: UNREACH};
    init_row[oa] = '0;
  end

  // Shared min-plus unit: one frontier cost against a table row, all lanes at once.
  always_comb begin
    acc_row = best_q;
    for (int k = 0; k < LAYER_WIDTH; k++) begin
      if (mid_ok_q && OFF_W'(k) < ls && sat_add(a_q[o1_q], rdata[k]) < best_q[k]) begin
        acc_row[k] = sat_add(a_q[o1_q], rdata[k]);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_size_q <= 3'd5;
      node_count_q <= NCNT_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LAYER_SIZE: layer_size_q <= cfg_data_i[2:0];
        CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:    if (clr_q == ADDR_W'(ROW_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_e'(kind_i))
            KIND_EDGE, KIND_QUERY: state_d = S_DIV;
            KIND_BUILD:            state_d = (LEVELS > 1) ? S_BRA : S_OUT;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_DIV:    state_d = (kind_e'(kind_q) == KIND_EDGE) ? S_EREM : S_QREM;
      S_EREM:   state_d = edge_ok ? S_EWR : S_IDLE;
      S_EWR:    state_d = S_IDLE;
      S_QREM:   state_d = q_bad ? S_OUT : S_QBIT;
      S_QBIT: begin
        if (d_q[j_q])              state_d = S_MRD;
        else if (j_q == '0)        state_d = S_OUT;
      end
      S_BRA:    state_d = S_BBASE;
      S_BBASE:  state_d = S_MRD;
      S_MRD:    state_d = S_ACC;
      S_ACC: begin
        if (o1_q == ls - OFF_W'(1)) state_d = build_q ? S_BWR : S_QUPD;
        else                        state_d = S_MRD;
      end
      S_BWR: begin
        if (i_q == NODE_W'(NODES - 1) && j_q == LVL_W'(LEVELS - 1)) state_d = S_OUT;
        else                                                      state_d = S_BRA;
      end
      S_QUPD:   state_d = (j_q == '0) ? S_OUT : S_QBIT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // RAM controls and input stall.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = clr_q;
    ram_raddr  = '0;
    wdata      = '{default: UNREACH};
    case (state_q)
      S_CLR: ram_we = 1'b1;
      S_EREM: ram_raddr = row_addr(from_q, '0);
      S_EWR: begin
        ram_we    = 1'b1;
        ram_waddr = row_addr(from_q, '0);
        wdata     = rdata;
        if (COST_W'(toll_q) < rdata[off_q]) wdata[off_q] = COST_W'(toll_q);
      end
      S_BRA: ram_raddr = row_addr(i_q, rlvl);
      S_MRD: ram_raddr = row_addr(mid[NODE_W-1:0], rlvl);
      S_BWR: begin
        ram_we    = 1'b1;
        ram_waddr = row_addr(i_q, j_q);
        if (NCNT_W'(i_q) < node_count_q) wdata = best_q;
      end
      default: ;
    endcase
  end

  // Clear-pass address counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == S_CLR) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Datapath registers, updated per sequencer step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        kind_q  <= kind_i;
        from_q  <= from_node_i;
        to_q    <= to_node_i;
        toll_q  <= toll_i;
        build_q <= (kind_e'(kind_i) == KIND_BUILD);
        j_q     <= LVL_W'(1);
        i_q     <= '0;
        li_q    <= '0;
        oi_q    <= '0;
        pend_kind_q <= (kind_e'(kind_i) == KIND_BUILD);
        pend_cost_q <= UNREACH;
      end
      S_DIV: begin
        la_q <= div_ls(from_q, ls);
        lb_q <= div_ls(to_q, ls);
      end
      S_EREM: off_q <= OFF_W'(to_q - NODE_W'(lb_q * NODE_W'(ls)));
      S_QREM: begin
        ob_q    <= OFF_W'(to_q - NODE_W'(lb_q * NODE_W'(ls)));
        a_q     <= init_row;
        d_q     <= lb_q - la_q;
        layer_q <= la_q;
        j_q     <= LVL_W'(LEVELS - 1);
      end
      S_QBIT: begin
        base_q <= MID_W'(MID_W'(layer_q) * MID_W'(ls));
        o1_q   <= '0;
        best_q <= '{default: UNREACH};
        if (!d_q[j_q]) begin
          if (j_q == '0) pend_cost_q <= a_q[ob_q];
          else           j_q <= j_q - LVL_W'(1);
        end
      end
      S_BBASE: begin
        a_q    <= rdata;
        base_q <= MID_W'((MID_W'(li_q) + (MID_W'(1) << (j_q - LVL_W'(1)))) * MID_W'(ls));
        o1_q   <= '0;
        best_q <= '{default: UNREACH};
      end
      S_MRD: mid_ok_q <= (mid < MID_W'(node_count_q)) && (mid < MID_W'(NODES));
      S_ACC: begin
        best_q <= acc_row;
        o1_q   <= o1_q + OFF_W'(1);
      end
      S_QUPD: begin
        a_q     <= best_q;
        layer_q <= layer_q + (NODE_W'(1) << j_q);
        if (j_q == '0) pend_cost_q <= best_q[ob_q];
        else           j_q <= j_q - LVL_W'(1);
      end
      S_BWR: begin
        if (i_q == NODE_W'(NODES - 1)) begin
          i_q  <= '0;
          li_q <= '0;
          oi_q <= '0;
          j_q  <= j_q + LVL_W'(1);
        end else begin
          i_q <= i_q + NODE_W'(1);
          if (oi_q == ls - OFF_W'(1)) begin
            oi_q <= '0;
            li_q <= li_q + NODE_W'(1);
          end else begin
            oi_q <= oi_q + OFF_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      answer_kind_o <= pend_kind_q;
      reachable_o   <= !pend_kind_q && (pend_cost_q < UNREACH);
      cost_o        <= (!pend_kind_q && pend_cost_q < UNREACH) ? pend_cost_q[OUTC_W-1:0] : '0;
    end
  end

  // Jump table: one row holds a node's tolls at one level to every offset of the target layer.
  lgmt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROW_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ROW_W'(wdata)),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_raw)
  );

endmodule

FILE: test/layered_graph_min_toll_query_test.sv
// Self-checking testbench for the layered least-toll query block.
// Depends on lgmt_pkg and layered_graph_min_toll_query; a scoreboard class predicts every result.
// Edges, builds and queries are sent under several layer sizes and node counts.
module layered_graph_min_toll_query_test;
  import lgmt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8000000;
  localparam int unsigned TABLE_SIZE  = NODES * LEVELS * LAYER_WIDTH;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned HOLD_CYCLES = 2000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [TOLL_W-1:0] toll;
  } item_t;

  typedef struct packed {
    logic              answer_kind;
    logic              reachable;
    logic [OUTC_W-1:0] cost;
  } answer_t;

  // Scoreboard: keeps its own toll table and predicts build and query answers.
  class toll_board;
    cost_t          hop_cost [TABLE_SIZE];
    logic [2:0]     layer_size;
    logic [12:0]    node_count;
    answer_t        pending [$];
    int unsigned    errors, n_edges, n_builds, n_reach, n_unreach;

    function new();
      foreach (hop_cost[k]) hop_cost[k] = UNREACH;
      layer_size = 3'd5;
      node_count = 13'd4096;
    endfunction

    function int unsigned eff_size();
      if (layer_size == 3'd0) return 1;
      if (layer_size > LAYER_WIDTH) return LAYER_WIDTH;
      return layer_size;
    endfunction

    function void set_config(logic [2:0] ls, logic [12:0] nc);
      layer_size = ls;
      node_count = nc;
    endfunction

    function cost_t toll_sum(cost_t a, cost_t b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a >= UNREACH || b >= UNREACH || s >= {1'b0, UNREACH}) return UNREACH;
      return s[COST_W-1:0];
    endfunction

    function int unsigned slot_of(int unsigned node, int unsigned lvl, int unsigned off);
      return (node * LEVELS + lvl) * LAYER_WIDTH + off;
    endfunction

    // Nodes out of range or out of use have no outgoing tolls.
    function cost_t hop(int unsigned node, int unsigned lvl, int unsigned off);
      if (node >= NODES || node >= node_count || lvl >= LEVELS || off >= LAYER_WIDTH)
        return UNREACH;
      return hop_cost[slot_of(node, lvl, off)];
    endfunction

    // Level j is level j-1 composed with itself, 2^(j-1) layers further on.
    function void fill_levels();
      int unsigned ls, mid;
      cost_t best, c;
      ls = eff_size();
      for (int unsigned j = 1; j < LEVELS; j++) begin
        for (int unsigned i = 0; i < NODES; i++) begin
          for (int unsigned o2 = 0; o2 < LAYER_WIDTH; o2++) begin
            best = UNREACH;
            if (i < node_count && o2 < ls) begin
              for (int unsigned o1 = 0; o1 < ls; o1++) begin
                mid = (i / ls + (1 << (j - 1))) * ls + o1;
                c = toll_sum(hop(i, j - 1, o1), hop(mid, j - 1, o2));
                if (c < best) best = c;
              end
            end
            hop_cost[slot_of(i, j, o2)] = best;
          end
        end
      end
    endfunction

    // Walks the set bits of the layer distance from the top level down.
    function cost_t least_toll(int unsigned a, int unsigned b);
      cost_t cur [LAYER_WIDTH];
      cost_t nxt [LAYER_WIDTH];
      cost_t best, c;
      int unsigned ls, la, lb, d, layer;
      ls = eff_size();
      la = a / ls;
      lb = b / ls;
      if (lb < la) return UNREACH;
      d = lb - la;
      if ((d >> LEVELS) != 0) return UNREACH;
      foreach (cur[k]) cur[k] = UNREACH;
      cur[a - la * ls] = '0;
      layer = la;
      for (int j = LEVELS - 1; j >= 0; j--) begin
        if (d[j]) begin
          for (int unsigned o2 = 0; o2 < LAYER_WIDTH; o2++) begin
            best = UNREACH;
            if (o2 < ls) begin
              for (int unsigned o1 = 0; o1 < ls; o1++) begin
                c = toll_sum(cur[o1], hop(layer * ls + o1, j, o2));
                if (c < best) best = c;
              end
            end
            nxt[o2] = best;
          end
          cur = nxt;
          layer += 1 << j;
        end
      end
      return cur[b - lb * ls];
    endfunction

    // Records an accepted item and queues the answer it must produce.
    function void note(item_t it);
      int unsigned ls, a, b, s;
      answer_t ans;
      cost_t c;
      ls = eff_size();
      a = it.from_node;
      b = it.to_node;
      case (it.kind)
        KIND_EDGE: begin
          if (b / ls == a / ls + 1) begin
            s = slot_of(a, 0, b - (b / ls) * ls);
            if (cost_t'(it.toll) < hop_cost[s]) hop_cost[s] = cost_t'(it.toll);
            n_edges++;
          end
        end
        KIND_BUILD: begin
          fill_levels();
          ans = '{answer_kind: 1'b1, reachable: 1'b0, cost: '0};
          pending = {pending, ans};
          n_builds++;
        end
        KIND_QUERY: begin
          c = least_toll(a, b);
          if (c >= UNREACH) begin
            ans = '{answer_kind: 1'b0, reachable: 1'b0, cost: '0};
            n_unreach++;
          end else begin
            ans = '{answer_kind: 1'b0, reachable: 1'b1, cost: c[OUTC_W-1:0]};
            n_reach++;
          end
          pending = {pending, ans};
        end
        default: ;
      endcase
    endfunction

    function void check(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: answer_kind %0d cost %0d", got.answer_kind, got.cost);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.answer_kind !== want.answer_kind) begin
        $error("answer_kind: expected %0d, got %0d", want.answer_kind, got.answer_kind);
        errors++;
      end
      if (got.reachable !== want.reachable) begin
        $error("reachable: expected %0d, got %0d", want.reachable, got.reachable);
        errors++;
      end
      if (got.cost !== want.cost) begin
        $error("cost: expected %0d, got %0d", want.cost, got.cost);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CFG_LAYER_SIZE;
  logic [NCNT_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        kind_i = KIND_NONE;
  logic [NODE_W-1:0] from_node_i = '0;
  logic [NODE_W-1:0] to_node_i = '0;
  logic [TOLL_W-1:0] toll_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              answer_kind_o;
  logic              reachable_o;
  logic [OUTC_W-1:0] cost_o;

  toll_board   board = new();
  int unsigned sent;
  int unsigned idle_mode;
  int unsigned cycles;
  int unsigned hold_left;
  bit          hold_kick;
  bit          hold_used;

  layered_graph_min_toll_query i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .from_node_i, .to_node_i, .toll_i,
    .out_valid_o, .out_stall_i, .answer_kind_o, .reachable_o, .cost_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, and result checking.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      board.check('{answer_kind: answer_kind_o, reachable: reachable_o, cost: cost_o});
    end
    if (hold_kick && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (idle_mode)
        0: out_stall_i <= ($urandom_range(99) < 61);
        1: out_stall_i <= ($urandom_range(99) < 31);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // Offers one item, idling first at random, and notes it once accepted.
  task automatic send(item_t it);
    int unsigned pct;
    pct = (idle_mode == 0) ? 31 : (idle_mode == 1) ? 61 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= it.kind;
    from_node_i <= it.from_node;
    to_node_i   <= it.to_node;
    toll_i      <= it.toll;
    do @(posedge clk_i); while (in_stall_o);
    board.note(it);
    sent++;
    idle_mode = (sent < 570) ? 0 : (sent < 1140) ? 1 : 2;
  endtask

  task automatic send_fields(logic [1:0] k, int unsigned a, int unsigned b, int unsigned t);
    send('{kind: k, from_node: NODE_W'(a), to_node: NODE_W'(b), toll: TOLL_W'(t)});
  endtask

  // Drains all answers, lets a late add-edge finish, then writes both registers.
  task automatic set_config(logic [2:0] ls, logic [12:0] nc);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LAYER_SIZE;
    cfg_data_i <= NCNT_W'(ls);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NODE_COUNT;
    cfg_data_i <= nc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_config(ls, nc);
  endtask

  // Random item: mostly edges and queries within the first twelve layers,
  // with some fully random noise, unknown kinds included.
  function automatic item_t random_item(int unsigned query_pct);
    item_t it;
    int unsigned ls, win, r, la, a;
    ls  = board.eff_size();
    win = 12 * ls;
    r   = $urandom_range(99);
    it.toll = ($urandom_range(1)) ? TOLL_W'($urandom_range(255)) : TOLL_W'($urandom);
    if (r < 8) begin
      it.kind      = ($urandom_range(2) == 0) ? KIND_NONE :
                     ($urandom_range(1) ? KIND_EDGE : KIND_QUERY);
      it.from_node = NODE_W'($urandom);
      it.to_node   = NODE_W'($urandom);
      it.toll      = TOLL_W'($urandom);
    end else if (r < 8 + query_pct) begin
      a            = $urandom_range(win - 1);
      it.kind      = KIND_QUERY;
      it.from_node = NODE_W'(a);
      it.to_node   = NODE_W'($urandom_range(win - 1, a));
    end else begin
      la           = $urandom_range(10);
      it.kind      = KIND_EDGE;
      it.from_node = NODE_W'(la * ls + $urandom_range(ls - 1));
      it.to_node   = NODE_W'((la + 1) * ls + $urandom_range(ls - 1));
    end
    return it;
  endfunction

  task automatic random_run(int unsigned count, int unsigned query_pct);
    repeat (count) send(random_item(query_pct));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, ignored edges, unknown kind, stale levels, same-layer queries.
    send_fields(KIND_EDGE, 0, 5, 0);
    send_fields(KIND_EDGE, 0, 6, 16383);
    send_fields(KIND_EDGE, 0, 5, 7);
    send_fields(KIND_EDGE, 5, 10, 100);
    send_fields(KIND_EDGE, 4090, 4095, 16383);
    send_fields(KIND_EDGE, 4095, 4094, 1);
    send_fields(KIND_EDGE, 0, 10, 3);
    send_fields(KIND_EDGE, 6, 0, 3);
    send_fields(KIND_NONE, 4095, 4095, 16383);
    send_fields(KIND_QUERY, 0, 0, 0);
    send_fields(KIND_QUERY, 0, 1, 0);
    send_fields(KIND_QUERY, 5, 0, 0);
    send_fields(KIND_QUERY, 0, 5, 0);
    send_fields(KIND_QUERY, 0, 10, 0);
    send_fields(KIND_QUERY, 4090, 4095, 16383);
    random_run(150, 10);
    send_fields(KIND_BUILD, 0, 0, 0);
    send_fields(KIND_QUERY, 0, 10, 0);
    send_fields(KIND_QUERY, 0, 59, 0);
    send_fields(KIND_QUERY, 0, 4095, 0);
    random_run(250, 60);

    // One node per layer, few nodes in use.
    set_config(3'd1, 13'd20);
    random_run(120, 10);
    send_fields(KIND_BUILD, 4095, 4095, 16383);
    random_run(350, 60);

    // Clamped layer sizes and other node counts over the stale levels;
    // the receiver holds off for a while so that the block fills up.
    set_config(3'd7, 13'd4096);
    hold_kick = 1'b1;
    random_run(300, 50);
    set_config(3'd0, 13'd1);
    random_run(150, 50);
    set_config(3'd3, 13'd4095);
    random_run(450, 50);

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d items: %0d layered edges, %0d builds, %0d queries answered",
             sent, board.n_edges, board.n_builds, board.n_reach + board.n_unreach);
    $display("Of the queries %0d were reachable and %0d unreachable",
             board.n_reach, board.n_unreach);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
